// ===== rtl/path_canonicalizer_top_macros.svh =====
// Assertion macros used by the datapath of the path canonicaliser.
`ifndef PATH_CANONICALIZER_TOP_MACROS_SVH
`define PATH_CANONICALIZER_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("path canonicaliser assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define PC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("path canonicaliser assertion failed");

`endif

// ===== rtl/pc_pkg.sv =====
package pc_pkg;

  localparam int PC_MAX_PATH     = 64;
  localparam int PC_MAX_SEGMENTS = 32;

  localparam logic [7:0] SLASH_CHAR = 8'h2F;
  localparam logic [7:0] DOT_CHAR   = 8'h2E;

  // Classification of the segment being received.
  localparam logic [1:0] CLASS_EMPTY  = 2'd0;
  localparam logic [1:0] CLASS_DOT    = 2'd1;
  localparam logic [1:0] CLASS_DOTDOT = 2'd2;
  localparam logic [1:0] CLASS_OTHER  = 2'd3;

  typedef struct packed {
    logic accept;
    logic store_slash;
    logic store_char;
    logic close;
    logic pop;
    logic load;
    logic root;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic slash;
    logic last;
    logic dot_empty;
    logic pop_needed;
    logic wp_zero;
    logic emit_done;
    logic out_free;
  } status_t;

endpackage

// ===== rtl/pc_in_if.sv =====
interface pc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] path_byte;
  logic       last_byte;

  modport source (output valid, output path_byte, output last_byte, input ready);
  modport sink (input valid, input path_byte, input last_byte, output ready);
endinterface

// ===== rtl/pc_out_if.sv =====
interface pc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;
  logic       overflow;

  modport source (output valid, output out_byte, output out_last, output overflow,
                  input ready);
  modport sink (input valid, input out_byte, input out_last, input overflow,
                output ready);
endinterface

// ===== rtl/pc_ram.sv =====
module pc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/pc_ctrl.sv =====
module pc_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  pc_pkg::status_t status,
  output pc_pkg::cmd_t    cmd
);
  import pc_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_STEP    = 3'd1;
  localparam logic [2:0] S_CHAR    = 3'd2;
  localparam logic [2:0] S_CLOSE   = 3'd3;
  localparam logic [2:0] S_POP1    = 3'd4;
  localparam logic [2:0] S_POP2    = 3'd5;
  localparam logic [2:0] S_EMIT_RD = 3'd6;
  localparam logic [2:0] S_EMIT_LD = 3'd7;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_STEP;
        end
      end
      S_STEP: begin
        if (status.slash) begin
          cmd.close = 1'b1;
          if (status.pop_needed) begin
            state_nxt = S_POP1;
          end else if (status.last) begin
            state_nxt = S_CLOSE;
          end else begin
            state_nxt = S_IDLE;
          end
        end else if (status.dot_empty) begin
          // A new segment opens with its separator before the character itself.
          cmd.store_slash = 1'b1;
          state_nxt       = S_CHAR;
        end else begin
          cmd.store_char = 1'b1;
          state_nxt      = status.last ? S_CLOSE : S_IDLE;
        end
      end
      S_CHAR: begin
        cmd.store_char = 1'b1;
        state_nxt      = status.last ? S_CLOSE : S_IDLE;
      end
      S_CLOSE: begin
        cmd.close = 1'b1;
        state_nxt = status.pop_needed ? S_POP2 : S_EMIT_RD;
      end
      S_POP1: begin
        cmd.pop   = 1'b1;
        state_nxt = status.last ? S_CLOSE : S_IDLE;
      end
      S_POP2: begin
        cmd.pop   = 1'b1;
        state_nxt = S_EMIT_RD;
      end
      S_EMIT_RD: begin
        // The store read is issued only once the output register will be free.
        if (status.out_free) begin
          if (status.wp_zero) begin
            cmd.root  = 1'b1;
            cmd.clear = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_EMIT_LD;
          end
        end
      end
      S_EMIT_LD: begin
        cmd.load = 1'b1;
        if (status.emit_done) begin
          cmd.clear = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_EMIT_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/pc_datapath.sv =====
`include "path_canonicalizer_top_macros.svh"

module pc_datapath #(
  parameter int MAX_PATH     = pc_pkg::PC_MAX_PATH,
  parameter int MAX_SEGMENTS = pc_pkg::PC_MAX_SEGMENTS
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [7:0]      path_byte,
  input  logic            last_byte,
  input  logic            out_ready,
  output logic            out_valid,
  output logic [7:0]      out_byte,
  output logic            out_last,
  output logic            overflow,
  input  pc_pkg::cmd_t    cmd,
  output pc_pkg::status_t status
);
  import pc_pkg::*;

  localparam int PW = $clog2(MAX_PATH + 1);
  localparam int AW = $clog2(MAX_PATH);
  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam int SW = $clog2(MAX_SEGMENTS);

  logic [7:0]    byte_r;
  logic          last_r;
  logic [PW-1:0] wp_r, wp_nxt;
  logic [PW-1:0] cs_r, cs_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [1:0]    dot_r, dot_nxt;
  logic          ovf_r, ovf_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [7:0]    out_byte_r;
  logic          out_last_r;
  logic          out_ovf_r;

  logic          char_we;
  logic [7:0]    char_wdata;
  logic [7:0]    char_rdata;
  logic          seg_we;
  logic [CW-1:0] cnt_dec;
  logic [PW-1:0] seg_rdata;
  logic          room;
  logic          emit_done;

  assign room      = (wp_r < PW'(MAX_PATH));
  assign cnt_dec   = cnt_r - CW'(1);
  assign emit_done = ((PW'(idx_r) + PW'(1)) == wp_r);

  pc_ram #(.WIDTH(8), .DEPTH(MAX_PATH)) u_char_store (
    .clk   (clk),
    .we    (char_we),
    .waddr (wp_r[AW-1:0]),
    .wdata (char_wdata),
    .raddr (idx_r),
    .rdata (char_rdata)
  );

  // The read address always points at the top of the segment stack, ready for a pop.
  pc_ram #(.WIDTH(PW), .DEPTH(MAX_SEGMENTS)) u_seg_starts (
    .clk   (clk),
    .we    (seg_we),
    .waddr (cnt_r[SW-1:0]),
    .wdata (cs_r),
    .raddr (cnt_dec[SW-1:0]),
    .rdata (seg_rdata)
  );

  always_comb begin
    wp_nxt     = wp_r;
    cs_nxt     = cs_r;
    cnt_nxt    = cnt_r;
    dot_nxt    = dot_r;
    ovf_nxt    = ovf_r;
    idx_nxt    = idx_r;
    char_we    = 1'b0;
    char_wdata = cmd.store_slash ? SLASH_CHAR : byte_r;
    seg_we     = 1'b0;

    if (cmd.store_slash || cmd.store_char) begin
      if (room) begin
        char_we = 1'b1;
        wp_nxt  = wp_r + PW'(1);
      end else begin
        ovf_nxt = 1'b1;
      end
    end
    if (cmd.store_slash) begin
      cs_nxt = wp_r;
    end
    if (cmd.store_char) begin
      if (byte_r == DOT_CHAR && dot_r == CLASS_EMPTY) begin
        dot_nxt = CLASS_DOT;
      end else if (byte_r == DOT_CHAR && dot_r == CLASS_DOT) begin
        dot_nxt = CLASS_DOTDOT;
      end else begin
        dot_nxt = CLASS_OTHER;
      end
    end

    if (cmd.close) begin
      case (dot_r)
        CLASS_DOT: begin
          wp_nxt = cs_r;
        end
        CLASS_DOTDOT: begin
          // The stored start of the popped segment is read out in the following cycle.
          wp_nxt = cs_r;
          if (cnt_r != '0) begin
            cnt_nxt = cnt_dec;
          end
        end
        CLASS_OTHER: begin
          if (wp_r != cs_r) begin
            if (cnt_r < CW'(MAX_SEGMENTS)) begin
              seg_we  = 1'b1;
              cnt_nxt = cnt_r + CW'(1);
            end else begin
              wp_nxt  = cs_r;
              ovf_nxt = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
      dot_nxt = CLASS_EMPTY;
    end

    if (cmd.pop) begin
      wp_nxt = seg_rdata;
    end

    if (cmd.load) begin
      idx_nxt = idx_r + AW'(1);
    end

    if (cmd.clear) begin
      wp_nxt  = '0;
      cs_nxt  = '0;
      cnt_nxt = '0;
      dot_nxt = CLASS_EMPTY;
      ovf_nxt = 1'b0;
      idx_nxt = '0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    if (cmd.load || cmd.root) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r        <= '0;
      cs_r        <= '0;
      cnt_r       <= '0;
      dot_r       <= CLASS_EMPTY;
      ovf_r       <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      wp_r        <= wp_nxt;
      cs_r        <= cs_nxt;
      cnt_r       <= cnt_nxt;
      dot_r       <= dot_nxt;
      ovf_r       <= ovf_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      byte_r <= path_byte;
      last_r <= last_byte;
    end
    if (cmd.load) begin
      out_byte_r <= char_rdata;
      out_last_r <= emit_done;
      out_ovf_r  <= ovf_r;
    end else if (cmd.root) begin
      out_byte_r <= SLASH_CHAR;
      out_last_r <= 1'b1;
      out_ovf_r  <= ovf_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;
  assign overflow  = out_ovf_r;

  assign status.slash      = (byte_r == SLASH_CHAR);
  assign status.last       = last_r;
  assign status.dot_empty  = (dot_r == CLASS_EMPTY);
  assign status.pop_needed = (dot_r == CLASS_DOTDOT) && (cnt_r != '0);
  assign status.wp_zero    = (wp_r == '0);
  assign status.emit_done  = emit_done;
  assign status.out_free   = !out_valid_r || out_ready;

  `PC_ASSERT_IMP(a_wp_bound, clk, rst_n, 1'b1, wp_r <= PW'(MAX_PATH))
  `PC_ASSERT_IMP(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= CW'(MAX_SEGMENTS))
  `PC_ASSERT_IMP(a_load_free, clk, rst_n, cmd.load || cmd.root, !out_valid_r || out_ready)
  `PC_ASSERT_NXT(a_clear, clk, rst_n, cmd.clear, wp_r == '0 && cnt_r == '0 && out_valid_r)

endmodule

// ===== rtl/path_canonicalizer_top.sv =====
// Each byte is taken only in the idle state; the first byte of a segment also stores its
// leading slash. The final byte then adds its close, and each emitted character is read
// through the registered read of the character store (a lone "/" needs no read); the emit
// pass waits while the sink holds ready low.
// No new byte is taken until the emit pass has loaded the path's last character for output.
// Reset (rst_n low, synchronous) clears the controller, counters, pointers and output valid;
// the character store and segment stack are not cleared and need no clearing pass.
module path_canonicalizer_top #(
  parameter int MAX_PATH     = pc_pkg::PC_MAX_PATH,
  parameter int MAX_SEGMENTS = pc_pkg::PC_MAX_SEGMENTS
) (
  input logic      clk,
  input logic      rst_n,
  pc_in_if.sink    in_ch,
  pc_out_if.source out_ch
);
  import pc_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic    in_ready;

  pc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  pc_datapath #(
    .MAX_PATH     (MAX_PATH),
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .path_byte (in_ch.path_byte),
    .last_byte (in_ch.last_byte),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_byte  (out_ch.out_byte),
    .out_last  (out_ch.out_last),
    .overflow  (out_ch.overflow),
    .cmd       (cmd),
    .status    (status)
  );

  assign in_ch.ready = in_ready;

endmodule

// ===== verif/tb_path_canonicalizer_top.sv =====
module tb_path_canonicalizer_top;
  import pc_pkg::*;

  localparam int unsigned QUIET_LIMIT = 3000;
  localparam int unsigned TAIL_CYCLES = 100;
  localparam int unsigned LONG_HOLD   = 400;
  localparam int unsigned TOTAL_BYTES = 140;

  typedef struct {
    logic [7:0] ch;
    logic       last;
    bit         wait_for_drain;
  } path_item_t;

  typedef struct {
    logic [7:0] ch;
    logic       last;
    logic       ovf;
  } canon_char_t;

  logic clk;
  logic rst_n;

  pc_in_if  in_ch ();
  pc_out_if out_ch ();

  path_canonicalizer_top DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  path_item_t  pending_bytes[$];
  canon_char_t expected_chars[$];
  int unsigned mismatches;
  int unsigned bytes_taken;
  int unsigned quiet_cycles;

  // Shadow copy of the canonicaliser state.
  logic [7:0]  canon_text[PC_MAX_PATH];
  int unsigned canon_seg_base[PC_MAX_SEGMENTS];
  int unsigned canon_depth;
  int unsigned canon_wr;
  int unsigned canon_open;
  logic [1:0]  canon_class;
  logic        canon_dropped;

  function automatic void canon_put(logic [7:0] c);
    if (canon_wr < PC_MAX_PATH) begin
      canon_text[canon_wr] = c;
      canon_wr++;
    end else begin
      canon_dropped = 1'b1;
    end
  endfunction

  function automatic void canon_take(logic [7:0] c);
    if (canon_class == CLASS_EMPTY) begin
      canon_open = canon_wr;
      canon_put(SLASH_CHAR);
    end
    canon_put(c);
    if (c == DOT_CHAR && canon_class == CLASS_EMPTY) canon_class = CLASS_DOT;
    else if (c == DOT_CHAR && canon_class == CLASS_DOT) canon_class = CLASS_DOTDOT;
    else canon_class = CLASS_OTHER;
  endfunction

  function automatic void canon_close_segment();
    case (canon_class)
      CLASS_DOT: canon_wr = canon_open;
      CLASS_DOTDOT: begin
        canon_wr = canon_open;
        if (canon_depth > 0) begin
          canon_depth--;
          canon_wr = canon_seg_base[canon_depth];
        end
      end
      CLASS_OTHER: begin
        // A segment whose leading slash found the store full leaves no trace.
        if (canon_wr != canon_open) begin
          if (canon_depth < PC_MAX_SEGMENTS) begin
            canon_seg_base[canon_depth] = canon_open;
            canon_depth++;
          end else begin
            canon_wr      = canon_open;
            canon_dropped = 1'b1;
          end
        end
      end
      default: ;
    endcase
    canon_class = CLASS_EMPTY;
  endfunction

  function automatic void canon_clear();
    canon_depth   = 0;
    canon_wr      = 0;
    canon_open    = 0;
    canon_class   = CLASS_EMPTY;
    canon_dropped = 1'b0;
  endfunction

  function automatic void canon_accept(logic [7:0] c, logic is_last);
    canon_char_t r;
    if (c == SLASH_CHAR) canon_close_segment();
    else canon_take(c);
    if (!is_last) return;
    canon_close_segment();
    if (canon_wr == 0) begin
      r.ch   = SLASH_CHAR;
      r.last = 1'b1;
      r.ovf  = canon_dropped;
      expected_chars = {expected_chars, r};
    end else begin
      for (int unsigned i = 0; i < canon_wr; i++) begin
        r.ch   = canon_text[i];
        r.last = (i + 1 == canon_wr);
        r.ovf  = canon_dropped;
        expected_chars = {expected_chars, r};
      end
    end
    canon_clear();
  endfunction

  task automatic report_mismatch(string what);
    mismatches++;
    if (mismatches <= 30) $display("mismatch at %0t: %s", $time, what);
  endtask

  task automatic check_canon_char();
    canon_char_t want;
    if (expected_chars.size() == 0) begin
      report_mismatch($sformatf("unexpected character %h", out_ch.out_byte));
      return;
    end
    want = expected_chars.pop_front();
    if (out_ch.out_byte !== want.ch)
      report_mismatch($sformatf("out_byte %h, expected %h", out_ch.out_byte, want.ch));
    if (out_ch.out_last !== want.last)
      report_mismatch($sformatf("out_last %b, expected %b", out_ch.out_last, want.last));
    if (out_ch.overflow !== want.ovf)
      report_mismatch($sformatf("overflow %b, expected %b", out_ch.overflow, want.ovf));
  endtask

  // Stimulus construction.
  function automatic logic [7:0] pick_path_char();
    int unsigned r = $urandom_range(0, 99);
    if (r < 15) return DOT_CHAR;
    if (r < 25) return SLASH_CHAR;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic void queue_path(logic [7:0] text[$], bit drain_first);
    path_item_t it;
    for (int i = 0; i < text.size(); i++) begin
      it.ch             = text[i];
      it.last           = (i == text.size() - 1);
      it.wait_for_drain = drain_first && (i == 0);
      pending_bytes = {pending_bytes, it};
    end
  endfunction

  function automatic void queue_text(string s);
    logic [7:0] text[$];
    for (int i = 0; i < s.len(); i++) text = {text, 8'(s[i])};
    queue_path(text, 1'b0);
  endfunction

  function automatic void queue_random_path(bit drain_first);
    logic [7:0]  text[$];
    int unsigned nseg;
    int unsigned len;
    bit          deep;
    deep = ($urandom_range(0, 9) == 0);
    if ($urandom_range(0, 6) == 0) begin
      // Noise: arbitrary bytes with many dots and slashes.
      len = $urandom_range(1, 12);
      for (int i = 0; i < len; i++) text = {text, pick_path_char()};
    end else begin
      if ($urandom_range(0, 1)) text = {text, SLASH_CHAR};
      nseg = deep ? $urandom_range(4, 10) : $urandom_range(0, 6);
      for (int s = 0; s < nseg; s++) begin
        if (s > 0) text = {text, SLASH_CHAR};
        case ($urandom_range(0, 9))
          0: ;
          1, 2: text = {text, DOT_CHAR};
          3, 4: begin
            text = {text, DOT_CHAR};
            text = {text, DOT_CHAR};
          end
          default: begin
            len = deep ? $urandom_range(4, 20) : $urandom_range(1, 5);
            for (int i = 0; i < len; i++) begin
              text = {text, (($urandom_range(0, 7) == 0) ? DOT_CHAR
                                                         : 8'($urandom_range(0, 255)))};
            end
          end
        endcase
      end
      if ($urandom_range(0, 3) == 0) text = {text, SLASH_CHAR};
    end
    if (text.size() == 0) text = {text, pick_path_char()};
    queue_path(text, drain_first);
  endfunction

  function automatic void queue_full_stack_path();
    logic [7:0] text[$];
    // Thirty-two one-character segments fill the store exactly; the next one
    // overflows, and the trailing ".." then drops the last kept segment.
    for (int s = 0; s < PC_MAX_SEGMENTS + 1; s++) begin
      text = {text, SLASH_CHAR};
      text = {text, 8'($urandom_range(0, 255)) | 8'h80};
    end
    text = {text, SLASH_CHAR};
    text = {text, DOT_CHAR};
    text = {text, DOT_CHAR};
    queue_path(text, 1'b0);
  endfunction

  // Idle patterns; the calm flags give stretches with no gaps at all.
  bit in_calm;
  bit out_calm;

  function automatic int unsigned pick_gap(bit calm);
    int unsigned r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Sender.
  int unsigned in_gap;
  path_item_t  in_next;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid     <= 1'b0;
      in_ch.path_byte <= 8'h00;
      in_ch.last_byte <= 1'b0;
      in_gap = 0;
    end else if (!(in_ch.valid && !in_ch.ready)) begin
      if (in_gap > 0) begin
        in_gap--;
        in_ch.valid <= 1'b0;
      end else if (pending_bytes.size() == 0) begin
        in_ch.valid <= 1'b0;
      end else if (pending_bytes[0].wait_for_drain &&
                   (in_ch.valid || expected_chars.size() != 0)) begin
        // Hold back until the previous transaction's results have all come.
        in_ch.valid <= 1'b0;
      end else begin
        in_next = pending_bytes.pop_front();
        in_ch.valid     <= 1'b1;
        in_ch.path_byte <= in_next.ch;
        in_ch.last_byte <= in_next.last;
        if ($urandom_range(0, 39) == 0) in_calm = !in_calm;
        in_gap = pick_gap(in_calm);
      end
    end
  end

  // Receiver.
  int unsigned out_stall;
  int unsigned out_hold;
  bit          long_hold_done;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      out_stall = 0;
      out_hold  = 0;
    end else if (out_hold > 0) begin
      out_hold--;
      out_ch.ready <= 1'b0;
    end else if (!long_hold_done && bytes_taken >= 60) begin
      long_hold_done = 1'b1;
      out_hold = LONG_HOLD;
      out_ch.ready <= 1'b0;
    end else if (out_stall > 0) begin
      out_stall--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      if ($urandom_range(0, 39) == 0) out_calm = !out_calm;
      out_stall = pick_gap(out_calm);
    end
  end

  // Monitor: results are checked before the same edge's input is predicted.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) check_canon_char();
      if (in_ch.valid && in_ch.ready) begin
        canon_accept(in_ch.path_byte, in_ch.last_byte);
        bytes_taken++;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("** path_canonicalizer_top: FAILED **");
    $finish;
  end

  initial begin
    clk             = 1'b0;
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.path_byte = 8'h00;
    in_ch.last_byte = 1'b0;
    out_ch.ready    = 1'b0;
    mismatches      = 0;
    bytes_taken     = 0;
    quiet_cycles    = 0;
    in_calm         = 1'b0;
    out_calm        = 1'b0;
    long_hold_done  = 1'b0;
    canon_clear();

    queue_text("/");
    queue_text(".");
    queue_text("..");
    queue_text("a/./../b");
    queue_path('{8'h00, 8'hFF}, 1'b0);
    queue_text("//x/");
    queue_text("...");
    queue_text(".a");
    queue_random_path(1'b1);
    queue_full_stack_path();
    while (pending_bytes.size() < TOTAL_BYTES) queue_random_path(1'b0);
    queue_random_path(1'b1);
    queue_random_path(1'b0);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_bytes.size() != 0 || in_ch.valid) @(posedge clk);
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0 && expected_chars.size() == 0)
      $display("** path_canonicalizer_top: PASSED **");
    else
      $display("** path_canonicalizer_top: FAILED **");
    $finish;
  end

endmodule
